// ===== rtl/core/shabh_pkg.sv =====
// ============================================================================
// shabh_pkg
// Shared types and constants for the SHA-256 byte hasher.
// ============================================================================
`default_nettype none

package shabh_pkg;

    typedef enum logic [5:0] {
        ST_FILL   = 6'b000001,
        ST_PAD    = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_ROUND  = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    localparam logic [31:0] INIT_H [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha256_byte_hasher.sv =====
// ============================================================================
// sha256_byte_hasher
// SHA-256 over a byte stream: one byte per item, padding and length on the
// end-of-message item, eight digest words out.
// ============================================================================
//
//  channel  | dir | tdata                       | tuser    | tlast
//  ---------+-----+-----------------------------+----------+---------------
//  s_axis   | in  | [7:0] data_byte             | has_byte | end_of_message
//  m_axis   | out | [31:0] digest_word,         | -        | last_word
//           |     | [34:32] word_index, 0 above |          |
//
//  Bytes are taken one per cycle while a block fills.
//  A full block holds input off while the hash memory is read into the working
//  registers, 64 rounds run (one per cycle), and the sums are written back.
//  End of message feeds padding at one byte per cycle; each digest word is read
//  only after the sink has taken the one before; a stalled sink holds the digest.
//  Reset is immediate: 8 written flags make the hash memory read as the IV.
`default_nettype none

module sha256_byte_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             m_axis_tlast
);

    shabh_pkg::state_t state_reg, state_next;

    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic        pad_active_reg, pad_active_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_phase_reg, len_phase_next;
    logic        done_reg, done_next;
    logic [3:0]  iss_reg, iss_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  out_cnt_reg, out_cnt_next;
    logic [7:0]  hv_reg, hv_next;
    logic        rd_vld_reg;
    logic [2:0]  rd_idx_reg;
    logic        rd_wr_reg;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_word_reg;
    logic [2:0]  m_idx_reg;

    logic [31:0] hash_mem [0:7];
    logic [31:0] hm_q;
    logic        rd_en;
    logic [2:0]  rd_addr;
    logic        hm_we;
    logic [31:0] rdata;

    logic [23:0] acc_reg;
    logic [31:0] w_reg [0:15];
    logic [31:0] v_reg [0:7];

    logic        s_acc;
    logic        m_acc;
    logic        out_final;
    logic        push_en;
    logic [7:0]  push_byte;
    logic [7:0]  pad_byte;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    logic        w_shift;
    logic [31:0] w_in;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    assign s_acc     = s_axis_tvalid & s_axis_tready;
    assign m_acc     = m_valid_reg & m_axis_tready;
    assign out_final = m_acc & (m_idx_reg == 3'd7);

    assign bit_len  = {len_reg[60:0], 3'b000};
    assign len_byte = bit_len[{~fill_reg[2:0], 3'b000} +: 8];
    assign pad_byte = pad_first_reg ? shabh_pkg::PAD_MARK
                    : (len_phase_reg ? len_byte : 8'h00);

    assign push_en   = (state_reg == shabh_pkg::ST_PAD)
                     | ((state_reg == shabh_pkg::ST_FILL) & s_acc & s_axis_tuser);
    assign push_byte = (state_reg == shabh_pkg::ST_PAD) ? pad_byte : s_axis_tdata;

    assign rdata = rd_wr_reg ? hm_q : shabh_pkg::INIT_H[rd_idx_reg];
    assign hm_we = (state_reg == shabh_pkg::ST_UPDATE) & rd_vld_reg;

    // round datapath: a..h = v_reg[0..7]
    assign t1 = v_reg[7] + shabh_pkg::big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + shabh_pkg::ROUND_K[rnd_reg] + w_reg[0];
    assign t2 = shabh_pkg::big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new = shabh_pkg::small_sigma1(w_reg[14]) + w_reg[9]
                 + shabh_pkg::small_sigma0(w_reg[1]) + w_reg[0];

    assign w_shift = (push_en & (fill_reg[1:0] == 2'b11))
                   | (state_reg == shabh_pkg::ST_ROUND);
    assign w_in    = (state_reg == shabh_pkg::ST_ROUND) ? w_new : {acc_reg, push_byte};

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = iss_reg[2:0];
        case (state_reg)
            shabh_pkg::ST_LOAD, shabh_pkg::ST_UPDATE:
            begin
                rd_en = ~iss_reg[3];
            end
            shabh_pkg::ST_OUT:
            begin
                rd_en   = ~m_valid_reg & ~rd_vld_reg;
                rd_addr = out_cnt_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = push_en ? fill_reg + 6'd1 : fill_reg;
        len_next        = len_reg;
        pad_active_next = pad_active_reg;
        pad_first_next  = pad_first_reg;
        len_phase_next  = len_phase_reg;
        done_next       = done_reg;
        iss_next        = 4'd0;
        rnd_next        = 6'd0;
        out_cnt_next    = out_cnt_reg;
        hv_next         = hv_reg;
        m_valid_next    = m_valid_reg;
        if (hm_we)
        begin
            hv_next[rd_idx_reg] = 1'b1;
        end
        case (state_reg)
            shabh_pkg::ST_FILL:
            begin
                if (s_acc)
                begin
                    if (s_axis_tuser)
                    begin
                        len_next = len_reg + 64'd1;
                    end
                    if (s_axis_tlast)
                    begin
                        pad_active_next = 1'b1;
                        pad_first_next  = 1'b1;
                    end
                    if (s_axis_tuser && fill_reg == 6'd63)
                    begin
                        state_next = shabh_pkg::ST_LOAD;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = shabh_pkg::ST_PAD;
                    end
                end
            end
            shabh_pkg::ST_PAD:
            begin
                pad_first_next = 1'b0;
                if (!len_phase_reg && fill_reg == shabh_pkg::LEN_START - 6'd1)
                begin
                    len_phase_next = 1'b1;
                end
                if (len_phase_reg && fill_reg == 6'd63)
                begin
                    done_next = 1'b1;
                end
                if (fill_reg == 6'd63)
                begin
                    state_next = shabh_pkg::ST_LOAD;
                end
            end
            shabh_pkg::ST_LOAD:
            begin
                iss_next = iss_reg + {3'd0, ~iss_reg[3]};
                if (rd_vld_reg && rd_idx_reg == 3'd7)
                begin
                    state_next = shabh_pkg::ST_ROUND;
                end
            end
            shabh_pkg::ST_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = shabh_pkg::ST_UPDATE;
                end
            end
            shabh_pkg::ST_UPDATE:
            begin
                iss_next = iss_reg + {3'd0, ~iss_reg[3]};
                if (rd_vld_reg && rd_idx_reg == 3'd7)
                begin
                    if (done_reg)
                    begin
                        state_next = shabh_pkg::ST_OUT;
                    end
                    else if (pad_active_reg)
                    begin
                        state_next = shabh_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = shabh_pkg::ST_FILL;
                    end
                end
            end
            shabh_pkg::ST_OUT:
            begin
                if (rd_vld_reg)
                begin
                    m_valid_next = 1'b1;
                end
                if (m_acc)
                begin
                    m_valid_next = 1'b0;
                    out_cnt_next = out_cnt_reg + 3'd1;
                end
                if (out_final)
                begin
                    state_next      = shabh_pkg::ST_FILL;
                    len_next        = 64'd0;
                    pad_active_next = 1'b0;
                    pad_first_next  = 1'b0;
                    len_phase_next  = 1'b0;
                    done_next       = 1'b0;
                    out_cnt_next    = 3'd0;
                    hv_next         = 8'd0;
                end
            end
            default:
            begin
                state_next = shabh_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= shabh_pkg::ST_FILL;
            fill_reg       <= 6'd0;
            len_reg        <= 64'd0;
            pad_active_reg <= 1'b0;
            pad_first_reg  <= 1'b0;
            len_phase_reg  <= 1'b0;
            done_reg       <= 1'b0;
            iss_reg        <= 4'd0;
            rnd_reg        <= 6'd0;
            out_cnt_reg    <= 3'd0;
            hv_reg         <= 8'd0;
            rd_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            len_reg        <= len_next;
            pad_active_reg <= pad_active_next;
            pad_first_reg  <= pad_first_next;
            len_phase_reg  <= len_phase_next;
            done_reg       <= done_next;
            iss_reg        <= iss_next;
            rnd_reg        <= rnd_next;
            out_cnt_reg    <= out_cnt_next;
            hv_reg         <= hv_next;
            rd_vld_reg     <= rd_en;
            m_valid_reg    <= m_valid_next;
        end
    end

    // hash memory; update reads entry n while writing n-1, so no overlap
    always_ff @(posedge clk)
    begin
        if (hm_we)
        begin
            hash_mem[rd_idx_reg] <= rdata + v_reg[rd_idx_reg];
        end
        if (rd_en)
        begin
            hm_q <= hash_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_idx_reg <= rd_addr;
            rd_wr_reg  <= hv_reg[rd_addr];
        end
        if (push_en)
        begin
            acc_reg <= {acc_reg[15:0], push_byte};
        end
        if (w_shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_in;
        end
        if (state_reg == shabh_pkg::ST_LOAD && rd_vld_reg)
        begin
            v_reg[rd_idx_reg] <= rdata;
        end
        else if (state_reg == shabh_pkg::ST_ROUND)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
        if (state_reg == shabh_pkg::ST_OUT && rd_vld_reg)
        begin
            m_word_reg <= rdata;
            m_idx_reg  <= rd_idx_reg;
        end
    end

    assign s_axis_tready = (state_reg == shabh_pkg::ST_FILL);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, m_idx_reg, m_word_reg};
    assign m_axis_tlast  = (m_idx_reg == 3'd7);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input open while digest pending");

    a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shabh_pkg::ST_ROUND || state_reg == shabh_pkg::ST_LOAD
         || state_reg == shabh_pkg::ST_UPDATE) |-> fill_reg == 6'd0)
        else $error("fill count not zero during compression");

    a_rd_issue: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(rd_en))
        else $error("read data without a read");

    a_final_reset: assert property (@(posedge clk) disable iff (!rst_n)
        out_final |=> (state_reg == shabh_pkg::ST_FILL && hv_reg == 8'd0
                       && len_reg == 64'd0))
        else $error("state not cleared after digest");

    a_write_update: assert property (@(posedge clk) disable iff (!rst_n)
        hm_we |-> $past(state_reg == shabh_pkg::ST_UPDATE))
        else $error("hash write outside update");
`endif

endmodule

`default_nettype wire
